>>> hdl/bbf_pkg.sv
// Shared types and constants for the bounded byte stream FIFO.
// Has no dependencies. bbf_engine and the top level use it through scoped names.
`timescale 1ns / 1ps

package bbf_pkg;

    localparam int DEF_STORE_DEPTH    = 64;
    localparam int DEF_COUNT_WIDTH    = 32;
    localparam int CMD_QUEUE_DEPTH    = 2;
    localparam int RESULT_QUEUE_DEPTH = 4;

    localparam int CAP_WIDTH   = 7;
    localparam int LEVEL_WIDTH = 7;
    localparam int TOTAL_WIDTH = 32;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_PEEK  = 2'd2;
    localparam logic [1:0] REQ_END   = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] request_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   byte_valid;
        logic                   last_of_run;
        logic                   write_accepted;
        logic [LEVEL_WIDTH-1:0] fill_level;
        logic [LEVEL_WIDTH-1:0] space_left;
        logic [TOTAL_WIDTH-1:0] total_written;
        logic [TOTAL_WIDTH-1:0] total_read;
        logic                   ended_flag;
        logic                   eof_flag;
        logic                   error_flag;
    } result_t;

endpackage

>>> hdl/bbf_fifo.sv
// Small synchronous queue used for the request side and the result side.
// Depends on nothing but its parameters; the array is read at the head only.
`timescale 1ns / 1ps

module bbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [LW-1:0]    count_reg;
    logic [LW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == LW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign dout    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hdl/bbf_engine.sv
// Back end: byte store, pointers, counters and flags; executes one request at a time.
// Depends on bbf_pkg for the request and result types and the request codes.
`timescale 1ns / 1ps

module bbf_engine #(
    parameter int STORE_DEPTH = bbf_pkg::DEF_STORE_DEPTH,
    parameter int COUNT_WIDTH = bbf_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic [bbf_pkg::CAP_WIDTH-1:0]                   capacity_limit,
    input  bbf_pkg::cmd_t                                   cmd,
    input  logic                                            cmd_avail,
    output logic                                            cmd_pop,
    input  logic [$clog2(bbf_pkg::RESULT_QUEUE_DEPTH+1)-1:0] res_level,
    output logic                                            res_push,
    output bbf_pkg::result_t                                res
);

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int HW = $clog2(STORE_DEPTH + 1);
    localparam int SW = HW + 1;
    localparam int RLW = $clog2(bbf_pkg::RESULT_QUEUE_DEPTH + 1);
    localparam int CW = bbf_pkg::CAP_WIDTH;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        rdata_reg;

    logic              state_reg;
    logic              state_next;
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     head_next;
    logic [HW-1:0]     held_reg;
    logic [HW-1:0]     held_next;
    logic [COUNT_WIDTH-1:0] written_reg;
    logic [COUNT_WIDTH-1:0] written_next;
    logic [COUNT_WIDTH-1:0] popped_reg;
    logic [COUNT_WIDTH-1:0] popped_next;
    logic              closed_reg;
    logic              closed_next;
    logic              fault_reg;
    logic              fault_next;
    logic [PW-1:0]     run_addr_reg;
    logic [PW-1:0]     run_addr_next;
    logic [HW-1:0]     run_left_reg;
    logic [HW-1:0]     run_left_next;

    logic              stage_vld_reg;
    logic              stage_vld_next;
    logic              stage_byte_reg;
    logic              stage_byte_next;
    logic              stage_last_reg;
    logic              stage_last_next;
    logic              stage_acc_reg;
    logic              stage_acc_next;

    logic              credit;
    logic              take;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;
    logic              mem_we;
    logic [CW-1:0]     cap_eff;
    logic [CW-1:0]     held_ext;
    logic [7:0]        held_byte;
    logic [7:0]        run_len;
    logic [HW-1:0]     run_n;
    logic [HW-1:0]     len_h;
    logic [SW-1:0]     tail_sum;
    logic [PW-1:0]     tail_ptr;
    logic [SW-1:0]     head_sum;
    logic [PW-1:0]     head_adv;
    logic [PW-1:0]     head_inc;
    logic [PW-1:0]     run_inc;

    // One read can be in flight in the stage, so leave a slot for it.
    assign credit = ({1'b0, res_level} + (RLW + 1)'(stage_vld_reg))
                    < (RLW + 1)'(bbf_pkg::RESULT_QUEUE_DEPTH);
    assign take    = (state_reg == ST_IDLE) && cmd_avail && credit;
    assign cmd_pop = take;

    assign cap_eff   = (capacity_limit > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : capacity_limit;
    assign held_ext  = CW'(held_reg);
    assign held_byte = 8'(held_reg);
    assign run_len   = (cmd.request_length < held_byte) ? cmd.request_length : held_byte;
    assign run_n     = HW'(run_len);
    assign len_h     = HW'(cmd.request_length);

    assign tail_sum = SW'(head_reg) + SW'(held_reg);
    assign tail_ptr = PW'((tail_sum >= SW'(STORE_DEPTH)) ? tail_sum - SW'(STORE_DEPTH) : tail_sum);
    assign head_sum = SW'(head_reg) + SW'(len_h);
    assign head_adv = PW'((head_sum >= SW'(STORE_DEPTH)) ? head_sum - SW'(STORE_DEPTH) : head_sum);
    assign head_inc = (head_reg == PW'(STORE_DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign run_inc  = (run_addr_reg == PW'(STORE_DEPTH - 1)) ? '0 : run_addr_reg + PW'(1);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        held_next       = held_reg;
        written_next    = written_reg;
        popped_next     = popped_reg;
        closed_next     = closed_reg;
        fault_next      = fault_reg;
        run_addr_next   = run_addr_reg;
        run_left_next   = run_left_reg;
        stage_vld_next  = 1'b0;
        stage_byte_next = stage_byte_reg;
        stage_last_next = stage_last_reg;
        stage_acc_next  = stage_acc_reg;
        rd_en           = 1'b0;
        rd_addr         = run_addr_reg;
        mem_we          = 1'b0;

        if (take)
        begin
            stage_vld_next  = 1'b1;
            stage_byte_next = 1'b0;
            stage_last_next = 1'b1;
            stage_acc_next  = 1'b0;
            case (cmd.req_type)
                bbf_pkg::REQ_WRITE:
                begin
                    if (!closed_reg && !fault_reg && (held_ext < cap_eff))
                    begin
                        mem_we         = 1'b1;
                        held_next      = held_reg + HW'(1);
                        written_next   = written_reg + COUNT_WIDTH'(1);
                        stage_acc_next = 1'b1;
                    end
                end
                bbf_pkg::REQ_END:
                begin
                    closed_next = 1'b1;
                end
                bbf_pkg::REQ_READ, bbf_pkg::REQ_PEEK:
                begin
                    // State moves at once; the run then streams from the old head.
                    if ((cmd.req_type == bbf_pkg::REQ_READ) && (held_reg != '0))
                    begin
                        if (cmd.request_length > held_byte)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            head_next   = head_adv;
                            held_next   = held_reg - len_h;
                            popped_next = popped_reg + COUNT_WIDTH'(len_h);
                        end
                    end
                    if (run_n != '0)
                    begin
                        rd_en           = 1'b1;
                        rd_addr         = head_reg;
                        stage_byte_next = 1'b1;
                        stage_last_next = (run_n == HW'(1));
                        run_addr_next   = head_inc;
                        run_left_next   = run_n - HW'(1);
                        if (run_n != HW'(1))
                        begin
                            state_next = ST_RUN;
                        end
                    end
                end
                default:
                begin
                    stage_vld_next = 1'b1;
                end
            endcase
        end
        else if ((state_reg == ST_RUN) && credit)
        begin
            rd_en           = 1'b1;
            rd_addr         = run_addr_reg;
            stage_vld_next  = 1'b1;
            stage_byte_next = 1'b1;
            stage_acc_next  = 1'b0;
            stage_last_next = (run_left_reg == HW'(1));
            run_addr_next   = run_inc;
            run_left_next   = run_left_reg - HW'(1);
            if (run_left_reg == HW'(1))
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            written_reg   <= '0;
            popped_reg    <= '0;
            closed_reg    <= 1'b0;
            fault_reg     <= 1'b0;
            run_addr_reg  <= '0;
            run_left_reg  <= '0;
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            written_reg   <= written_next;
            popped_reg    <= popped_next;
            closed_reg    <= closed_next;
            fault_reg     <= fault_next;
            run_addr_reg  <= run_addr_next;
            run_left_reg  <= run_left_next;
            stage_vld_reg <= stage_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_byte_reg <= stage_byte_next;
        stage_last_reg <= stage_last_next;
        stage_acc_reg  <= stage_acc_next;
        if (mem_we)
        begin
            mem[tail_ptr] <= cmd.data_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Status is taken from the state registers, which already hold the
    // values after the request that produced the staged beat.
    always_comb
    begin
        res_push           = stage_vld_reg;
        res.out_byte       = stage_byte_reg ? rdata_reg : 8'd0;
        res.byte_valid     = stage_byte_reg;
        res.last_of_run    = stage_last_reg;
        res.write_accepted = stage_acc_reg;
        res.fill_level     = bbf_pkg::LEVEL_WIDTH'(held_reg);
        res.space_left     = (cap_eff > held_ext)
                             ? bbf_pkg::LEVEL_WIDTH'(cap_eff - held_ext)
                             : '0;
        res.total_written  = bbf_pkg::TOTAL_WIDTH'(written_reg);
        res.total_read     = bbf_pkg::TOTAL_WIDTH'(popped_reg);
        res.ended_flag     = closed_reg;
        res.eof_flag       = closed_reg && (held_reg == '0);
        res.error_flag     = fault_reg;
    end

endmodule

>>> hdl/bounded_byte_stream_fifo.sv
// Top level of the bounded byte stream FIFO: request queue, execution engine,
// result queue and the capacity register. Depends on bbf_pkg, bbf_fifo, bbf_engine.
`timescale 1ns / 1ps

// Requests enter through a queue port: push with req_type, data_byte and
// request_length; a beat is taken when push is high and full is low. A write
// stores one byte if open, error-free and below capacity; a read copies up to
// request_length held bytes and removes them only if all were held, a peek
// copies them only, and an end request closes input.
// Results leave through a queue port: while empty is low the oldest result is
// on the result ports, and it is taken when pop is high. Each result carries
// the status after its request (fill level, free space, totals, flags).
// A request is registered in the request queue, the engine stage and the result
// queue in turn. A read or peek delivers one byte per engine cycle while the
// result queue has room, set by the single read port of the byte store.
// When pop stays low the result queue fills, the engine holds, and the request
// queue then raises full; nothing is dropped.
// The capacity register is written over cfg_valid/cfg_ready (always ready); the
// user must change it only while the block is idle, not enforced by the block.
// Reset clears queues, counters and flags and sets capacity 64; no clearing pass.
module bounded_byte_stream_fifo #(
    parameter int STORE_DEPTH = bbf_pkg::DEF_STORE_DEPTH,
    parameter int COUNT_WIDTH = bbf_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    data_byte,
    input  logic [7:0]                    request_length,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          byte_valid,
    output logic                          last_of_run,
    output logic                          write_accepted,
    output logic [bbf_pkg::LEVEL_WIDTH-1:0] fill_level,
    output logic [bbf_pkg::LEVEL_WIDTH-1:0] space_left,
    output logic [bbf_pkg::TOTAL_WIDTH-1:0] total_written,
    output logic [bbf_pkg::TOTAL_WIDTH-1:0] total_read,
    output logic                          ended_flag,
    output logic                          eof_flag,
    output logic                          error_flag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbf_pkg::CAP_WIDTH-1:0] cfg_data
);

    localparam int CQW = $clog2(bbf_pkg::CMD_QUEUE_DEPTH + 1);
    localparam int RQW = $clog2(bbf_pkg::RESULT_QUEUE_DEPTH + 1);

    logic [bbf_pkg::CAP_WIDTH-1:0] capacity_reg;
    bbf_pkg::cmd_t    cmd_in;
    bbf_pkg::cmd_t    cmd_head;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [CQW-1:0]   cmd_level;
    bbf_pkg::result_t res_in;
    bbf_pkg::result_t res_head;
    logic             res_push;
    logic             res_full;
    logic [RQW-1:0]   res_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bbf_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    assign cmd_in.req_type       = req_type;
    assign cmd_in.data_byte      = data_byte;
    assign cmd_in.request_length = request_length;

    bbf_fifo #(
        .WIDTH ($bits(bbf_pkg::cmd_t)),
        .DEPTH (bbf_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .full  (full),
        .empty (cmd_empty),
        .level (cmd_level)
    );

    bbf_engine #(
        .STORE_DEPTH (STORE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_limit (capacity_reg),
        .cmd            (cmd_head),
        .cmd_avail      (!cmd_empty && (cmd_level != '0)),
        .cmd_pop        (cmd_pop),
        .res_level      (res_level),
        .res_push       (res_push),
        .res            (res_in)
    );

    // The engine only issues a beat when the queue has room; push is also gated by full.
    bbf_fifo #(
        .WIDTH ($bits(bbf_pkg::result_t)),
        .DEPTH (bbf_pkg::RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push && !res_full),
        .din   (res_in),
        .pop   (pop),
        .dout  (res_head),
        .full  (res_full),
        .empty (empty),
        .level (res_level)
    );

    assign out_byte       = res_head.out_byte;
    assign byte_valid     = res_head.byte_valid;
    assign last_of_run    = res_head.last_of_run;
    assign write_accepted = res_head.write_accepted;
    assign fill_level     = res_head.fill_level;
    assign space_left     = res_head.space_left;
    assign total_written  = res_head.total_written;
    assign total_read     = res_head.total_read;
    assign ended_flag     = res_head.ended_flag;
    assign eof_flag       = res_head.eof_flag;
    assign error_flag     = res_head.error_flag;

endmodule
